[src/lscl_pkg.sv]
// Shared types and constants for the LRU slot cache lookup block.
package lscl_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned ENTRY_IDX_W = 6;
  localparam int unsigned S_DATA_W    = 72;
  localparam int unsigned M_DATA_W    = 8;

  localparam logic ACT_LOOKUP     = 1'b0;
  localparam logic ACT_INVALIDATE = 1'b1;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic clr_en;
    logic clr_full;
    logic commit;
    logic commit_flush;
  } lscl_cmd_t;

  typedef struct packed {
    logic match;
    logic last_cmp;
    logic out_free;
  } lscl_stat_t;

endpackage

[src/lscl_ctrl.sv]
// Sequencer for the slot cache: reset sweep, invalidate sweep, entry scan and commit.
module lscl_ctrl import lscl_pkg::*; #(
  parameter int unsigned N = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_action,
  output logic                  in_ready,
  input  lscl_stat_t            st,
  output lscl_cmd_t             cmd,
  output logic [$clog2(N)-1:0]  addr
);

  localparam int unsigned IW = $clog2(N);
  localparam logic [IW:0] CNT_END  = (IW + 1)'(N);
  localparam logic [IW:0] CNT_LAST = (IW + 1)'(N - 1);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_FLUSH,
    S_SCAN,
    S_DONE
  } state_t;

  state_t      state;
  logic [IW:0] cnt;
  logic        is_flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      cnt      <= '0;
      is_flush <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          cnt <= '0;
          if (in_valid) begin
            is_flush <= (in_action == ACT_INVALIDATE);
            state    <= (in_action == ACT_INVALIDATE) ? S_FLUSH : S_SCAN;
          end
        end
        S_FLUSH: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          if (cnt != CNT_END) begin
            cnt <= cnt + 1'b1;
          end
          if (st.match || st.last_cmp) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (st.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign addr     = cnt[IW-1:0];

  always_comb begin
    cmd              = '0;
    cmd.load         = (state == S_IDLE) && in_valid;
    cmd.rd_en        = (state == S_SCAN) && (cnt != CNT_END);
    cmd.clr_en       = (state == S_INIT) || (state == S_FLUSH);
    cmd.clr_full     = (state == S_INIT);
    cmd.commit       = (state == S_DONE) && st.out_free;
    cmd.commit_flush = is_flush;
  end

  property p_commit_needs_free;
    @(posedge clk) disable iff (rst) cmd.commit |-> st.out_free;
  endproperty
  a_commit_needs_free: assert property (p_commit_needs_free)
    else $error("commit while output busy");

  property p_ready_idle_only;
    @(posedge clk) disable iff (rst) in_ready |-> !(cmd.rd_en || cmd.clr_en || cmd.commit);
  endproperty
  a_ready_idle_only: assert property (p_ready_idle_only)
    else $error("ready while busy");

  property p_cmd_exclusive;
    @(posedge clk) disable iff (rst) $onehot0({cmd.load, cmd.rd_en, cmd.clr_en, cmd.commit});
  endproperty
  a_cmd_exclusive: assert property (p_cmd_exclusive)
    else $error("overlapping commands");

endmodule

[src/lscl_dp.sv]
// Slot cache datapath: entry memories, scan compare, victim tracking and result register.
module lscl_dp import lscl_pkg::*; #(
  parameter int unsigned N = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lscl_cmd_t                 cmd,
  input  logic [$clog2(N)-1:0]      addr,
  output lscl_stat_t                st,
  input  logic [COORD_W-1:0]        in_x,
  input  logic [COORD_W-1:0]        in_z,
  input  logic [STAMP_W-1:0]        in_frame,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_hit,
  output logic [ENTRY_IDX_W-1:0]    out_idx
);

  localparam int unsigned IW  = $clog2(N);
  localparam int unsigned EW  = 2 * COORD_W + STAMP_W;
  localparam logic [IW-1:0] IDX_LAST = IW'(N - 1);

  logic [EW-1:0]      ent_mem [N];
  logic               vld_mem [N];

  logic [COORD_W-1:0] want_x;
  logic [COORD_W-1:0] want_z;
  logic [STAMP_W-1:0] now;

  logic [EW-1:0]      ent_rd;
  logic               vld_rd;
  logic               cmp_valid;
  logic [IW-1:0]      cmp_idx;

  logic               found;
  logic [IW-1:0]      pick;
  logic [IW-1:0]      victim;
  logic [STAMP_W-1:0] victim_stamp;

  logic [COORD_W-1:0] rd_x;
  logic [COORD_W-1:0] rd_z;
  logic [STAMP_W-1:0] rd_stamp;
  logic               match;
  logic [IW-1:0]      res_idx;
  logic [IW+ENTRY_IDX_W-1:0] idx_ext;

  assign rd_x     = ent_rd[EW-1 -: COORD_W];
  assign rd_z     = ent_rd[STAMP_W +: COORD_W];
  assign rd_stamp = ent_rd[STAMP_W-1:0];
  assign match    = cmp_valid && !found && vld_rd && (rd_x == want_x) && (rd_z == want_z);
  assign res_idx  = found ? pick : victim;
  assign idx_ext  = {{ENTRY_IDX_W{1'b0}}, res_idx};

  assign st.match    = match;
  assign st.last_cmp = cmp_valid && (cmp_idx == IDX_LAST);
  assign st.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      ent_rd <= ent_mem[addr];
      vld_rd <= vld_mem[addr];
    end
    if (cmd.clr_en) begin
      vld_mem[addr] <= 1'b0;
      if (cmd.clr_full) begin
        ent_mem[addr] <= '0;
      end
    end else if (cmd.commit && !cmd.commit_flush) begin
      vld_mem[res_idx] <= 1'b1;
      ent_mem[res_idx] <= {want_x, want_z, now};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      want_x <= in_x;
      want_z <= in_z;
      now    <= in_frame;
    end
    cmp_idx <= addr;
    if (match) begin
      pick <= cmp_idx;
    end
    if (cmp_valid && !found) begin
      if (cmp_idx == '0 || rd_stamp < victim_stamp) begin
        victim       <= cmp_idx;
        victim_stamp <= rd_stamp;
      end
    end
    if (cmd.commit) begin
      out_hit <= !cmd.commit_flush && found;
      out_idx <= cmd.commit_flush ? '0 : idx_ext[ENTRY_IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.rd_en;
      if (cmd.load) begin
        found <= 1'b0;
      end else if (match) begin
        found <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  property p_commit_loads_out;
    @(posedge clk) disable iff (rst) cmd.commit |=> out_valid;
  endproperty
  a_commit_loads_out: assert property (p_commit_loads_out)
    else $error("result not presented after commit");

  property p_flush_no_hit;
    @(posedge clk) disable iff (rst) (cmd.commit && cmd.commit_flush) |=> !out_hit;
  endproperty
  a_flush_no_hit: assert property (p_flush_no_hit)
    else $error("invalidate reported a hit");

  property p_single_match;
    @(posedge clk) disable iff (rst) match |=> !match;
  endproperty
  a_single_match: assert property (p_single_match)
    else $error("second match in one scan");

endmodule

[src/lru_slot_cache_lookup.sv]
// Top level of the fully associative LRU slot cache lookup.
// Lookup: one entry compared per cycle; a miss scans every entry, an early hit ends the scan;
// the single read port of the entry memory sets the scan rate.
// Invalidate: clears the valid flag of every entry, one entry per cycle.
// One item at a time; a finished result may wait in the output register while the next is taken.
// After rst a clearing pass over every entry zeroes stamps and flags; no item taken meanwhile.
module lru_slot_cache_lookup import lscl_pkg::*; #(
  parameter int unsigned CACHE_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // action[0], slot_x[16:1], slot_z[32:17], frame[64:33]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata   // hit[0], entry_index[6:1]
);

  localparam int unsigned IW = $clog2(CACHE_ENTRIES);

  lscl_cmd_t              cmd;
  lscl_stat_t             st;
  logic [IW-1:0]          addr;
  logic                   out_hit;
  logic [ENTRY_IDX_W-1:0] out_idx;

  lscl_ctrl #(.N(CACHE_ENTRIES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_action (s_tdata[0]),
    .in_ready  (s_tready),
    .st        (st),
    .cmd       (cmd),
    .addr      (addr)
  );

  lscl_dp #(.N(CACHE_ENTRIES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .addr      (addr),
    .st        (st),
    .in_x      (s_tdata[16:1]),
    .in_z      (s_tdata[32:17]),
    .in_frame  (s_tdata[64:33]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_hit   (out_hit),
    .out_idx   (out_idx)
  );

  assign m_tdata = {1'b0, out_idx, out_hit};

endmodule

[dv/testbench.sv]
// Testbench for lru_slot_cache_lookup: directed and random lookup traffic checked against a shadow cache.
module testbench import lscl_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CACHE_N     = 64;
  localparam int POOL_N      = 96;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                   hit;
    logic [ENTRY_IDX_W-1:0] idx;
  } lookup_res_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  // shadow copy of the cache contents
  logic [COORD_W-1:0] shadow_x     [CACHE_N];
  logic [COORD_W-1:0] shadow_z     [CACHE_N];
  logic               shadow_valid [CACHE_N];
  logic [STAMP_W-1:0] shadow_stamp [CACHE_N];

  lookup_res_t pending_lookups[$];

  int err_count    = 0;
  int cycle_count  = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold_req  = 0;
  int rx_hold_left = 0;

  // slot working set for random traffic
  logic [COORD_W-1:0] hot_x [POOL_N];
  logic [COORD_W-1:0] hot_z [POOL_N];
  logic [STAMP_W-1:0] cur_frame;
  int                 hot_span;

  lru_slot_cache_lookup #(.CACHE_ENTRIES(CACHE_N)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: long hold on request, otherwise random stalls
  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left <= rx_hold_req;
      rx_hold_req = 0;
      m_tready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    lookup_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected item hit=%0d idx=%0d", $time, m_tdata[0], m_tdata[6:1]);
        err_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (m_tdata[0] !== want.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, want.hit, m_tdata[0]);
          err_count++;
        end
        if (m_tdata[6:1] !== want.idx) begin
          $display("%0t: entry_index expected %0d actual %0d", $time, want.idx, m_tdata[6:1]);
          err_count++;
        end
      end
    end
  end

  function automatic lookup_res_t cache_lookup(input logic act,
                                               input logic [COORD_W-1:0] sx,
                                               input logic [COORD_W-1:0] sz,
                                               input logic [STAMP_W-1:0] fr);
    lookup_res_t r;
    int          victim;
    int          pick;
    bit          found;
    r      = '0;
    victim = 0;
    pick   = 0;
    found  = 1'b0;
    if (act == ACT_INVALIDATE) begin
      for (int i = 0; i < CACHE_N; i++) shadow_valid[i] = 1'b0;
      return r;
    end
    for (int i = 0; i < CACHE_N && !found; i++) begin
      if (shadow_valid[i] && shadow_x[i] == sx && shadow_z[i] == sz) begin
        found = 1'b1;
        pick  = i;
      end else if (shadow_stamp[i] < shadow_stamp[victim]) begin
        victim = i;
      end
    end
    if (!found) begin
      pick               = victim;
      shadow_x[pick]     = sx;
      shadow_z[pick]     = sz;
      shadow_valid[pick] = 1'b1;
    end
    shadow_stamp[pick] = fr;
    r.hit = found;
    r.idx = pick[ENTRY_IDX_W-1:0];
    return r;
  endfunction

  task automatic send_item(input logic act, input logic [COORD_W-1:0] sx,
                           input logic [COORD_W-1:0] sz, input logic [STAMP_W-1:0] fr);
    s_tdata  <= {{(S_DATA_W - 1 - 2*COORD_W - STAMP_W){1'b0}}, fr, sz, sx, act};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_lookups.insert(pending_lookups.size(), cache_lookup(act, sx, sz, fr));
  endtask

  task automatic tx_gap();
    int n;
    n = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) n++;
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_item();
    int          k;
    int          pick;
    logic        act;
    logic [15:0] sx;
    logic [15:0] sz;
    logic [31:0] fr;
    pick = $urandom_range(0, 99);
    act  = ACT_LOOKUP;
    if ($urandom_range(0, 99) == 0) cur_frame = $urandom;
    cur_frame = cur_frame + $urandom_range(0, 2);
    fr = cur_frame;
    if ($urandom_range(0, 49) == 0) begin
      k = $urandom_range(0, POOL_N - 1);
      hot_x[k] = 16'($urandom);
      hot_z[k] = 16'($urandom);
    end
    k  = $urandom_range(0, hot_span - 1);
    sx = hot_x[k];
    sz = hot_z[k];
    if (pick < 3) begin
      act = ACT_INVALIDATE;
      sx  = 16'($urandom);
      sz  = 16'($urandom);
      fr  = $urandom;
    end else if (pick < 10) begin
      sx = 16'($urandom);
      sz = 16'($urandom);
      fr = $urandom;
    end
    send_item(act, sx, sz, fr);
  endtask

  task automatic run_random_phase(input int n, input int tx_pct, input int rx_pct,
                                  input int span);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    hot_span     = span;
    repeat (n) begin
      send_random_item();
      tx_gap();
    end
    drain_results();
  endtask

  // after reset every entry is invalid with tag zero and stamp zero
  task automatic test_reset_and_extremes();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_item(ACT_LOOKUP, 16'h0000, 16'h0000, 32'h0000_0000);
    send_item(ACT_LOOKUP, 16'h0000, 16'h0000, 32'h0000_0005);
    send_item(ACT_LOOKUP, 16'h8000, 16'h7fff, 32'hffff_ffff);
    send_item(ACT_LOOKUP, 16'h7fff, 16'h8000, 32'h0000_0001);
    send_item(ACT_LOOKUP, 16'hffff, 16'hffff, 32'h8000_0000);
    send_item(ACT_LOOKUP, 16'h8000, 16'h7fff, 32'h0000_0002);
    send_item(ACT_LOOKUP, 16'h7fff, 16'h8000, 32'h0000_0003);
    drain_results();
  endtask

  // flags cleared, tags and stamps kept; stale tags must not hit
  task automatic test_invalidate();
    send_item(ACT_INVALIDATE, 16'hffff, 16'hffff, 32'hffff_ffff);
    send_item(ACT_LOOKUP, 16'h0000, 16'h0000, 32'h0000_0007);
    send_item(ACT_LOOKUP, 16'h0000, 16'h0000, 32'h0000_0008);
    send_item(ACT_LOOKUP, 16'h8000, 16'h7fff, 32'h0000_0009);
    send_item(ACT_INVALIDATE, 16'h0000, 16'h0000, 32'h0000_0000);
    send_item(ACT_LOOKUP, 16'h8000, 16'h7fff, 32'h0000_000a);
    drain_results();
  endtask

  // plain unsigned stamp order across the 2^32 wrap
  task automatic test_stamp_wrap();
    send_item(ACT_LOOKUP, 16'h1234, 16'hedcb, 32'hffff_fffe);
    send_item(ACT_LOOKUP, 16'h1235, 16'hedcb, 32'hffff_ffff);
    send_item(ACT_LOOKUP, 16'h1236, 16'hedcb, 32'h0000_0000);
    send_item(ACT_LOOKUP, 16'h1237, 16'hedcb, 32'h0000_0000);
    send_item(ACT_LOOKUP, 16'h1234, 16'hedcb, 32'h0000_0000);
    send_item(ACT_LOOKUP, 16'h1238, 16'hedcb, 32'h0000_0001);
    drain_results();
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < POOL_N; i++) begin
      hot_x[i] = 16'($urandom);
      hot_z[i] = 16'($urandom);
    end
    hot_x[0] = 16'h8000;
    hot_z[0] = 16'h7fff;
    hot_x[1] = 16'h7fff;
    hot_z[1] = 16'h8000;
    cur_frame = $urandom_range(0, 1000);
    run_random_phase(165, 0, 0, 48);
    run_random_phase(165, 52, 0, POOL_N);
    cur_frame = 32'hffff_ff80;
    run_random_phase(165, 0, 52, 56);
    run_random_phase(165, 26, 26, POOL_N);
  endtask

  // receiver held off while the sender keeps offering items
  task automatic test_output_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hot_span     = 40;
    @(posedge clk);
    rx_hold_req = 600;
    repeat (24) send_random_item();
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_and_extremes();
    test_invalidate();
    test_stamp_wrap();
    test_random_traffic();
    test_output_backpressure();
    repeat (200) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    for (int i = 0; i < CACHE_N; i++) begin
      shadow_x[i]     = '0;
      shadow_z[i]     = '0;
      shadow_valid[i] = 1'b0;
      shadow_stamp[i] = '0;
    end
  end

endmodule

[sim.f]
src/lscl_pkg.sv
src/lscl_ctrl.sv
src/lscl_dp.sv
src/lru_slot_cache_lookup.sv
dv/testbench.sv
